// File: sv/opc_pkg.sv
// Shared constants, state encoding and control structs for the optical property combiner.
package opc_pkg;

    localparam int MAX_MECHANISMS = 16;
    localparam int DEPTH_BITS     = 32;

    localparam int G_W       = 16;
    localparam int OM_W      = 16;
    localparam int TAU_W     = 32;
    localparam int DEPTH_USE = (DEPTH_BITS < TAU_W) ? DEPTH_BITS : TAU_W;
    localparam logic [TAU_W-1:0] DEPTH_MASK = TAU_W'((64'd1 << DEPTH_USE) - 64'd1);

    localparam int SUM_W   = 36;
    localparam int WSUM_W  = 37;
    localparam int STERM_W = 34;
    localparam int WMAG_W  = 36;
    localparam int P1_W    = OM_W + TAU_W + 1;
    localparam int P2_W    = G_W + STERM_W + 1;
    localparam int RND_SH  = 15;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    localparam int DEN_W = 37;
    localparam int QUO_W = 17;
    localparam int NUM_W = DEN_W + QUO_W;
    localparam int DCNT_W = $clog2(QUO_W + 1);

    localparam int CNT_W = $clog2(MAX_MECHANISMS + 1);

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_CLOSE,
        ST_DIV_ALB,
        ST_DIV_ASYM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic mul1;
        logic mul2;
        logic accum;
        logic close;
        logic latch_alb;
        logic start_asym;
        logic latch_asym;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic closing;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

// File: sv/opc_div.sv
// Restoring divider, one quotient bit per cycle, with quotient overflow flag.
module opc_div
    import opc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quo,
    output logic             ovf
);

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [QUO_W-1:0]  low_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic              ovf_reg;
    logic [DEN_W:0]    trial;
    logic              fits;

    always_comb
    begin
        trial    = {rem_reg, low_reg[QUO_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[NUM_W-1:QUO_W];
            low_reg <= num[QUO_W-1:0];
            den_reg <= den;
            ovf_reg <= num[NUM_W-1:QUO_W] >= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign ovf  = ovf_reg;

endmodule

// File: sv/opc_dp.sv
// Datapath: input capture, product stages, saturating sums, ratio formation and output word.
module opc_dp
    import opc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    output logic [OUT_USER_W-1:0] m_tuser
);

    logic signed [G_W-1:0]    g_reg;
    logic [OM_W-1:0]          om_reg;
    logic [TAU_W-1:0]         tau_reg;
    logic                     last_reg;
    logic                     lastp_reg;
    logic [STERM_W-1:0]       sterm_reg;
    logic [WMAG_W-1:0]        wmag_reg;
    logic                     gneg_reg;

    logic [SUM_W-1:0]         depth_sum_reg;
    logic [SUM_W-1:0]         scatter_sum_reg;
    logic signed [WSUM_W-1:0] wsum_reg;
    logic [CNT_W-1:0]         count_reg;

    logic [SUM_W-1:0]         depth_snap_reg;
    logic [SUM_W-1:0]         scatter_snap_reg;
    logic signed [WSUM_W-1:0] wsum_snap_reg;
    logic                     zd_reg;
    logic                     zs_reg;
    logic                     lastp_snap_reg;
    logic [OM_W-1:0]          albedo_reg;
    logic [G_W-1:0]           asym_reg;

    logic                     out_valid_reg;
    logic [OUT_DATA_W-1:0]    out_data_reg;
    logic                     out_last_reg;
    logic [OUT_USER_W-1:0]    out_user_reg;

    logic [P1_W-1:0]          p1;
    logic [P2_W-1:0]          p2;
    logic [G_W-1:0]           gmag;
    logic [SUM_W:0]           depth_add;
    logic [SUM_W:0]           scatter_add;
    logic signed [WSUM_W+1:0] wsum_add;
    logic [SUM_W-1:0]         depth_next;
    logic [SUM_W-1:0]         scatter_next;
    logic signed [WSUM_W-1:0] wsum_next;
    logic [CNT_W:0]           count_inc;
    logic [DEN_W-1:0]         wmag_snap;
    logic [NUM_W-1:0]         div_num;
    logic [DEN_W-1:0]         div_den;
    logic                     div_start;
    logic                     div_done;
    logic [QUO_W-1:0]         div_quo;
    logic                     div_ovf;
    logic [OM_W-1:0]          albedo_next;
    logic [G_W-1:0]           asym_next;

    localparam logic [CNT_W:0]           MECH_LIMIT = (CNT_W + 1)'(MAX_MECHANISMS);
    localparam logic signed [WSUM_W+1:0] WSUM_HI =
        (WSUM_W + 2)'((64'd1 << (WSUM_W - 1)) - 64'd1);
    localparam logic signed [WSUM_W+1:0] WSUM_LO = -WSUM_HI - 2'sd1;
    localparam logic [QUO_W-1:0]         Q_ONE   = QUO_W'(32768);
    localparam logic [QUO_W-1:0]         Q_POSMAX = QUO_W'(32767);

    always_comb
    begin
        p1   = P1_W'(om_reg) * P1_W'(tau_reg) + P1_W'(64'd1 << (RND_SH - 1));
        gmag = g_reg[G_W-1] ? G_W'(-g_reg) : G_W'(g_reg);
        p2   = P2_W'(gmag) * P2_W'(sterm_reg) + P2_W'(64'd1 << (RND_SH - 1));

        depth_add    = {1'b0, depth_sum_reg} + (SUM_W + 1)'(tau_reg);
        scatter_add  = {1'b0, scatter_sum_reg} + (SUM_W + 1)'(sterm_reg);
        depth_next   = depth_add[SUM_W] ? SUM_MAX : depth_add[SUM_W-1:0];
        scatter_next = scatter_add[SUM_W] ? SUM_MAX : scatter_add[SUM_W-1:0];

        if (gneg_reg)
            wsum_add = (WSUM_W + 2)'(wsum_reg) - $signed({2'b00, wmag_reg});
        else
            wsum_add = (WSUM_W + 2)'(wsum_reg) + $signed({2'b00, wmag_reg});
        if (wsum_add > WSUM_HI)
            wsum_next = WSUM_W'(WSUM_HI);
        else if (wsum_add < WSUM_LO)
            wsum_next = WSUM_W'(WSUM_LO);
        else
            wsum_next = wsum_add[WSUM_W-1:0];

        count_inc    = {1'b0, count_reg} + 1'b1;
        stat.closing = last_reg || (count_inc >= MECH_LIMIT);

        wmag_snap = wsum_snap_reg[WSUM_W-1] ? DEN_W'(-wsum_snap_reg) : DEN_W'(wsum_snap_reg);
        if (cmd.close)
        begin
            div_num = (NUM_W'(scatter_sum_reg) << RND_SH) + NUM_W'(depth_sum_reg >> 1);
            div_den = DEN_W'(depth_sum_reg);
        end
        else
        begin
            div_num = (NUM_W'(wmag_snap) << RND_SH) + NUM_W'(scatter_snap_reg >> 1);
            div_den = DEN_W'(scatter_snap_reg);
        end
        div_start = cmd.close || cmd.start_asym;

        if (zd_reg)
            albedo_next = '0;
        else if (div_ovf || div_quo > Q_ONE)
            albedo_next = OM_W'(Q_ONE);
        else
            albedo_next = div_quo[OM_W-1:0];

        if (zs_reg)
            asym_next = '0;
        else if (wsum_snap_reg[WSUM_W-1])
            asym_next = (div_ovf || div_quo > Q_ONE) ? G_W'(Q_ONE) : G_W'(-div_quo);
        else
            asym_next = (div_ovf || div_quo > Q_POSMAX) ? G_W'(Q_POSMAX) : div_quo[G_W-1:0];

        stat.div_done = div_done;
        stat.out_free = !out_valid_reg || m_tready;
    end

    opc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .ovf   (div_ovf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_sum_reg   <= '0;
            scatter_sum_reg <= '0;
            wsum_reg        <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.accum)
            begin
                depth_sum_reg   <= depth_next;
                scatter_sum_reg <= scatter_next;
                wsum_reg        <= wsum_next;
                count_reg       <= stat.closing ? '0 : count_inc[CNT_W-1:0];
            end
            else if (cmd.close)
            begin
                depth_sum_reg   <= '0;
                scatter_sum_reg <= '0;
                wsum_reg        <= '0;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            g_reg     <= $signed(s_tdata[G_W-1:0]);
            om_reg    <= s_tdata[G_W+OM_W-1:G_W];
            tau_reg   <= s_tdata[G_W+OM_W+TAU_W-1:G_W+OM_W] & DEPTH_MASK;
            last_reg  <= s_tlast;
            lastp_reg <= s_tuser;
        end
        if (cmd.mul1)
            sterm_reg <= p1[P1_W-1:RND_SH];
        if (cmd.mul2)
        begin
            wmag_reg <= WMAG_W'(p2[P2_W-1:RND_SH]);
            gneg_reg <= g_reg[G_W-1];
        end
        if (cmd.close)
        begin
            depth_snap_reg   <= depth_sum_reg;
            scatter_snap_reg <= scatter_sum_reg;
            wsum_snap_reg    <= wsum_reg;
            zd_reg           <= depth_sum_reg == '0;
            zs_reg           <= scatter_sum_reg == '0;
            lastp_snap_reg   <= lastp_reg;
        end
        if (cmd.latch_alb)
            albedo_reg <= albedo_next;
        if (cmd.latch_asym)
            asym_reg <= asym_next;
        if (cmd.load_out)
        begin
            out_data_reg <= OUT_DATA_W'({depth_snap_reg, albedo_reg, asym_reg});
            out_user_reg <= {zd_reg, zs_reg};
            out_last_reg <= lastp_snap_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

// File: sv/opc_ctrl.sv
// Controller state machine sequencing capture, products, sums, divisions and output load.
module opc_ctrl
    import opc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = stat.closing ? ST_CLOSE : ST_IDLE;
            end
            ST_CLOSE:
            begin
                cmd.close  = 1'b1;
                state_next = ST_DIV_ALB;
            end
            ST_DIV_ALB:
            begin
                if (stat.div_done)
                begin
                    cmd.latch_alb  = 1'b1;
                    cmd.start_asym = 1'b1;
                    state_next     = ST_DIV_ASYM;
                end
            end
            ST_DIV_ASYM:
            begin
                if (stat.div_done)
                begin
                    cmd.latch_asym = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/optical_property_combiner_core.sv
// Top level of the optical property combiner: controller and datapath.
//
// Input stream: one word per mechanism (asymmetry, albedo, depth); tlast closes the
// spectral point, tuser carries the batch-end flag through to the result.
// Output stream: one word per spectral point with combined asymmetry, albedo and
// total depth; tuser holds the zero-scatter and zero-depth flags, tlast the batch end.
// Each input word passes capture, two product stages and accumulate before the next
// is accepted; tready is high only while the block waits for a word.
// A closing word then takes the snapshot of the sums, the albedo and asymmetry
// divisions in turn on the shared restoring divider and the load of the output
// register, which raises tvalid, before the next word is taken.
// The sixteenth word since the last result closes the point even without tlast.
// The result sits in an output register: while it waits for tready the block
// already accepts words of the next point, and stalls only when a second result
// is ready before the first has been taken.
// Reset clears the sums, the word count, the controller and the output valid.
module optical_property_combiner_core
    import opc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // asym_in, albedo_in, depth_in
    input  logic                  s_axis_tlast,
    input  logic                  s_axis_tuser,  // last_point
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // asym_out, albedo_out, depth_out, zero pad
    output logic                  m_axis_tlast,
    output logic [OUT_USER_W-1:0] m_axis_tuser   // zero_scatter, zero_depth
);

    cmd_t  cmd;
    stat_t stat;

    opc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    opc_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_axis_tdata),
        .s_tlast  (s_axis_tlast),
        .s_tuser  (s_axis_tuser),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tlast  (m_axis_tlast),
        .m_tuser  (m_axis_tuser)
    );

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the optical property combiner core.
module tb_top;
    import opc_pkg::*;

    localparam int  WORD_BUDGET = 1400;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  QUIET_LO    = 5000;
    localparam int  QUIET_HI    = 8000;
    localparam int  HOLD_AT     = 2500;
    localparam int  HOLD_LEN    = 800;
    localparam int  DRAIN_WAIT  = 100;
    localparam logic [63:0] ACC_MAX  = 64'h0000_000F_FFFF_FFFF;
    localparam longint      WSUM_HI  = 64'sd68719476735;
    localparam longint      WSUM_LO  = -64'sd68719476736;
    localparam logic [63:0] HALF_LSB = 64'd16384;

    typedef struct packed {
        logic             sync;
        logic             last_pt;
        logic             last_mech;
        logic [TAU_W-1:0] depth;
        logic [OM_W-1:0]  albedo;
        logic [G_W-1:0]   asym;
    } mech_word_t;

    typedef struct packed {
        logic [G_W-1:0]   asym;
        logic [OM_W-1:0]  albedo;
        logic [SUM_W-1:0] depth;
        logic             zero_scatter;
        logic             zero_depth;
        logic             batch_end;
    } point_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // asym_in, albedo_in, depth_in
    logic                  s_axis_tlast = 1'b0;
    logic                  s_axis_tuser = 1'b0; // last_point
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // asym_out, albedo_out, depth_out, zero pad
    logic                  m_axis_tlast;
    logic [OUT_USER_W-1:0] m_axis_tuser;        // zero_scatter, zero_depth

    mech_word_t    mech_q[$];
    point_result_t expected_points[$];
    mech_word_t    word_on_bus;
    point_result_t want;

    logic [63:0] depth_acc = '0;
    logic [63:0] scatter_acc = '0;
    longint      wasym_acc = 0;
    int          mech_cnt = 0;

    int  mismatches = 0;
    int  cycles = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  random_words = 0;
    wire idle_on = !(cycles >= QUIET_LO && cycles < QUIET_HI);

    optical_property_combiner_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    task automatic fold_mechanism(input mech_word_t w);
        longint        g;
        longint        wnext;
        logic [63:0]   tau, sterm, gmag, wmag, mag, q, qs, alb;
        bit            neg;
        point_result_t r;
        g     = $signed(w.asym);
        tau   = w.depth & DEPTH_MASK;
        sterm = (w.albedo * tau + HALF_LSB) >> RND_SH;
        gmag  = (g < 0) ? -g : g;
        wmag  = (gmag * sterm + HALF_LSB) >> RND_SH;

        depth_acc   = depth_acc + tau;
        if (depth_acc > ACC_MAX)
            depth_acc = ACC_MAX;
        scatter_acc = scatter_acc + sterm;
        if (scatter_acc > ACC_MAX)
            scatter_acc = ACC_MAX;
        wnext = (g < 0) ? wasym_acc - longint'(wmag) : wasym_acc + longint'(wmag);
        if (wnext > WSUM_HI)
            wnext = WSUM_HI;
        if (wnext < WSUM_LO)
            wnext = WSUM_LO;
        wasym_acc = wnext;
        mech_cnt++;

        if (w.last_mech || mech_cnt >= MAX_MECHANISMS) begin
            r = '0;
            if (depth_acc == 0) begin
                r.zero_depth = 1'b1;
            end else begin
                alb = ((scatter_acc << 15) + depth_acc / 2) / depth_acc;
                if (alb > 64'd32768)
                    alb = 64'd32768;
                r.albedo = alb[15:0];
            end
            if (scatter_acc == 0) begin
                r.zero_scatter = 1'b1;
            end else begin
                neg = wasym_acc < 0;
                mag = neg ? -wasym_acc : wasym_acc;
                q   = ((mag << 15) + scatter_acc / 2) / scatter_acc;
                if (neg && q > 64'd32768)
                    q = 64'd32768;
                if (!neg && q > 64'd32767)
                    q = 64'd32767;
                qs = neg ? -q : q;
                r.asym = qs[15:0];
            end
            r.depth     = depth_acc[SUM_W-1:0];
            r.batch_end = w.last_pt;
            expected_points.push_back(r);
            depth_acc   = '0;
            scatter_acc = '0;
            wasym_acc   = 0;
            mech_cnt    = 0;
        end
    endtask

    task automatic add_word(input logic [15:0] asym, input logic [15:0] albedo,
                            input logic [31:0] depth, input bit last_mech,
                            input bit last_pt, input bit sync);
        mech_word_t w;
        w.asym      = asym;
        w.albedo    = albedo;
        w.depth     = depth;
        w.last_mech = last_mech;
        w.last_pt   = last_pt;
        w.sync      = sync;
        mech_q.push_back(w);
    endtask

    function automatic logic [15:0] pick_asym();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_albedo();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [31:0] pick_depth();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom;
            4, 5, 6: return $urandom_range(0, 32'h0003_FFFF);
            default: return $urandom_range(0, 32'h00FF_FFFF);
        endcase
    endfunction

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin : stimulus
        int  kind;
        int  len;
        int  point_no;
        bit  sync;
        logic [15:0] asym, albedo;
        logic [31:0] depth;

        add_word(16'h7FFF, 16'd32768, 32'h0001_0000, 1'b1, 1'b1, 1'b0);
        add_word(16'h8000, 16'd32768, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        add_word(16'h0000, 16'd12345, 32'h0003_0000, 1'b1, 1'b0, 1'b0);
        add_word(16'h1234, 16'd12345, 32'd0,         1'b1, 1'b1, 1'b0);
        add_word(16'h4000, 16'd0,     32'h0005_0000, 1'b1, 1'b0, 1'b0);
        add_word(16'h4000, 16'hFFFF,  32'h000A_0000, 1'b1, 1'b0, 1'b0);
        add_word(16'h4000, 16'd16384, 32'h0002_0000, 1'b0, 1'b0, 1'b0);
        add_word(16'hC000, 16'd32768, 32'h0001_8000, 1'b1, 1'b1, 1'b0);
        for (int i = 0; i < MAX_MECHANISMS; i++)
            add_word(16'h8000, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, i == MAX_MECHANISMS - 1, 1'b0);

        point_no = 0;
        while (random_words < WORD_BUDGET) begin
            kind = $urandom_range(0, 19);
            sync = (point_no % 60) == 30;
            if (kind == 0)
                len = $urandom_range(17, 24);
            else if (kind == 3)
                len = MAX_MECHANISMS;
            else if (kind == 4)
                len = $urandom_range(1, 4);
            else
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                asym   = pick_asym();
                albedo = pick_albedo();
                depth  = pick_depth();
                if (kind == 1)
                    depth = 32'd0;
                if (kind == 2)
                    albedo = 16'd0;
                if (kind == 3) begin
                    asym   = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                    albedo = 16'($urandom_range(32768, 65535));
                    depth  = $urandom | 32'hF000_0000;
                end
                add_word(asym, albedo, depth,
                         (kind == 4) ? bit'($urandom_range(0, 1)) :
                         (kind != 0 && i == len - 1),
                         $urandom_range(0, 3) == 0, sync && i == 0);
                random_words++;
            end
            point_no++;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (mech_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            s_axis_tuser  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                fold_mechanism(word_on_bus);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (mech_q.size() != 0 && !(mech_q[0].sync && expected_points.size() != 0)
                        && !(idle_on && $urandom_range(0, 99) < 23)) begin
                    word_on_bus = mech_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {word_on_bus.depth, word_on_bus.albedo, word_on_bus.asym};
                    s_axis_tlast  <= word_on_bus.last_mech;
                    s_axis_tuser  <= word_on_bus.last_pt;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && cycles >= HOLD_AT) begin
            hold_left     <= HOLD_LEN;
            hold_done     <= 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 23);
        end
    end

    task automatic compare_field(input string name, input logic [35:0] exp_val,
                                 input logic [35:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected word expected none actual %0h", $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_points.pop_front();
                compare_field("asym_out", 36'(want.asym), 36'(m_axis_tdata[15:0]));
                compare_field("albedo_out", 36'(want.albedo), 36'(m_axis_tdata[31:16]));
                compare_field("depth_out", want.depth, m_axis_tdata[67:32]);
                compare_field("zero_scatter", 36'(want.zero_scatter), 36'(m_axis_tuser[0]));
                compare_field("zero_depth", 36'(want.zero_depth), 36'(m_axis_tuser[1]));
                compare_field("batch_end", 36'(want.batch_end), 36'(m_axis_tlast));
            end
        end
    end

endmodule

// File: files.f
sv/opc_pkg.sv
sv/opc_div.sv
sv/opc_dp.sv
sv/opc_ctrl.sv
sv/optical_property_combiner_core.sv
bench/tb_top.sv
